>>> design/hspd_pkg.sv
// types, constants and the quarter-wave sine table for the harmonic sine pwm duty block
package hspd_pkg;

    localparam int COEF_W   = 16;
    localparam int SINE_W   = 18;
    localparam int TERM_W   = 14;
    localparam int DUTY_W   = 11;
    localparam int PHASE_W  = 8;
    localparam int SLOT_W   = 6;
    localparam int NUM_HARM = 4;
    localparam int TERM_SHIFT  = 22;
    localparam int DRIVE_SHIFT = 20;

    typedef logic signed [COEF_W-1:0] t_coef;
    typedef logic signed [SINE_W-1:0] t_sine;
    typedef logic signed [TERM_W-1:0] t_term;

    // register indexes
    localparam logic CFG_DUTY_LIMIT = 1'b0;
    localparam logic CFG_JOIN_AMP   = 1'b1;

    // item modes
    localparam logic MODE_COMPUTE = 1'b0;
    localparam logic MODE_ADVANCE = 1'b1;

    localparam logic [DUTY_W-1:0] DUTY_LIMIT_RESET = 11'd1000;
    localparam logic [PHASE_W-1:0] QUARTER_TURN = 8'd64;

    localparam int HARM_MUL [NUM_HARM] = '{1, 3, 5, 7};

    // quarter-wave sine, unsigned q1.16 magnitude
    localparam logic [16:0] QUARTER_WAVE [65] = '{
        17'd0,     17'd1608,  17'd3215,  17'd4820,  17'd6423,  17'd8023,  17'd9615,  17'd11205,
        17'd12785, 17'd14359, 17'd15923, 17'd17480, 17'd19023, 17'd20557, 17'd22077, 17'd23585,
        17'd25080, 17'd26557, 17'd28019, 17'd29466, 17'd30894, 17'd32302, 17'd33692, 17'd35062,
        17'd36411, 17'd37737, 17'd39040, 17'd40320, 17'd41574, 17'd42806, 17'd44012, 17'd45189,
        17'd46341, 17'd47465, 17'd48558, 17'd49626, 17'd50660, 17'd51666, 17'd52639, 17'd53581,
        17'd54492, 17'd55368, 17'd56212, 17'd57021, 17'd57797, 17'd58540, 17'd59244, 17'd59914,
        17'd60547, 17'd61146, 17'd61706, 17'd62228, 17'd62715, 17'd63163, 17'd63572, 17'd63944,
        17'd64276, 17'd64571, 17'd64827, 17'd65042, 17'd65221, 17'd65359, 17'd65457, 17'd65516,
        17'd65536
    };

    // full-wave sine from the quarter table, mirrored by quadrant
    function automatic t_sine sine_rom(input logic [PHASE_W-1:0] addr);
        logic [6:0]  idx;
        logic [16:0] mag;
        idx = addr[6] ? (7'd64 - {1'b0, addr[5:0]}) : {1'b0, addr[5:0]};
        mag = QUARTER_WAVE[idx];
        return addr[7] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    endfunction

endpackage

>>> design/hspd_term.sv
// one harmonic term: sine and cosine weighted, truncated toward zero to an integer
module hspd_term (
    input  hspd_pkg::t_sine i_sin_val,
    input  hspd_pkg::t_sine i_cos_val,
    input  hspd_pkg::t_coef i_sin_coef,
    input  hspd_pkg::t_coef i_cos_coef,
    output hspd_pkg::t_term o_term
);

    logic signed [33:0] w_prod_s;
    logic signed [33:0] w_prod_c;
    logic signed [34:0] w_acc;
    logic signed [34:0] w_bias;
    logic signed [34:0] w_shift;

    assign w_prod_s = i_sin_val * i_sin_coef;
    assign w_prod_c = i_cos_val * i_cos_coef;
    assign w_acc    = 35'(w_prod_s) + 35'(w_prod_c);
    // round toward zero for negative sums
    assign w_bias   = w_acc[34] ? 35'sd4194303 : '0;
    assign w_shift  = (w_acc + w_bias) >>> hspd_pkg::TERM_SHIFT;
    assign o_term   = hspd_pkg::TERM_W'(w_shift);

endmodule

>>> design/harmonic_sine_pwm_duty.sv
// top level: phase oscillator, harmonic-injected duty computation and output register
// an accepted item passes the input stage, then the result stage that drives the outputs
// throughput: one item per cycle; an input stage and a result stage, each with its own valid
// the input stage refills while a result waits, so a stall costs no throughput until both fill
// reset: phase index 0, duty limit 1000, amplitude 0, both stages empty
module harmonic_sine_pwm_duty #(
    parameter int SINE_TABLE_STEPS = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_mode,
    input  logic signed [15:0] i_sin_first,
    input  logic signed [15:0] i_cos_first,
    input  logic signed [15:0] i_sin_third,
    input  logic signed [15:0] i_cos_third,
    input  logic signed [15:0] i_sin_fifth,
    input  logic signed [15:0] i_cos_fifth,
    input  logic signed [15:0] i_sin_seventh,
    input  logic signed [15:0] i_cos_seventh,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [10:0] o_high_duty,
    output logic [10:0] o_low_duty,
    output logic [7:0]  o_phase_index,
    output logic        o_period_start,
    output logic        o_slot_valid,
    output logic [5:0]  o_sample_slot
);

    localparam int PhaseMod = (SINE_TABLE_STEPS > 256) ? 256 :
                              ((SINE_TABLE_STEPS < 1) ? 1 : SINE_TABLE_STEPS);
    localparam int NH = hspd_pkg::NUM_HARM;

    // configuration
    logic [hspd_pkg::DUTY_W-1:0] r_limit;
    logic signed [15:0]          r_amp;

    // oscillator state
    logic [hspd_pkg::PHASE_W-1:0] r_phase;
    logic [hspd_pkg::PHASE_W-1:0] n_phase;

    // input stage
    logic                         r_s1_valid;
    logic                         r_s1_mode;
    hspd_pkg::t_coef              r_s1_sin [NH];
    hspd_pkg::t_coef              r_s1_cos [NH];
    logic [hspd_pkg::PHASE_W-1:0] r_s1_addr [NH];
    logic [hspd_pkg::PHASE_W-1:0] r_s1_phase;
    logic                         r_s1_pstart;
    logic                         r_s1_svalid;
    logic [hspd_pkg::SLOT_W-1:0]  r_s1_slot;

    // result stage
    logic                         r_out_valid;
    logic [hspd_pkg::DUTY_W-1:0]  r_high;
    logic [hspd_pkg::DUTY_W-1:0]  r_low;
    logic [hspd_pkg::PHASE_W-1:0] r_phase_out;
    logic                         r_pstart;
    logic                         r_svalid;
    logic [hspd_pkg::SLOT_W-1:0]  r_slot;

    logic w_in_acc;
    logic w_s2_en;

    hspd_pkg::t_coef              w_sin_in [NH];
    hspd_pkg::t_coef              w_cos_in [NH];
    logic [hspd_pkg::PHASE_W-1:0] w_addr_tab [NH][256];
    hspd_pkg::t_sine              w_sin_v [NH];
    hspd_pkg::t_sine              w_cos_v [NH];
    hspd_pkg::t_term              w_term [NH];

    logic signed [33:0] w_drive_p;
    logic signed [33:0] w_drive_bias;
    logic signed [33:0] w_drive_sh;
    logic signed [15:0] w_duty;
    logic signed [15:0] w_lim;
    logic signed [15:0] w_duty_c;
    logic signed [15:0] w_duty_neg;
    logic [hspd_pkg::DUTY_W-1:0] n_high;
    logic [hspd_pkg::DUTY_W-1:0] n_low;

    assign w_s2_en    = !(r_out_valid && i_out_stall);
    assign o_in_stall = r_s1_valid && !w_s2_en;
    assign w_in_acc   = i_in_valid && !o_in_stall;

    assign w_sin_in[0] = i_sin_first;
    assign w_cos_in[0] = i_cos_first;
    assign w_sin_in[1] = i_sin_third;
    assign w_cos_in[1] = i_cos_third;
    assign w_sin_in[2] = i_sin_fifth;
    assign w_cos_in[2] = i_cos_fifth;
    assign w_sin_in[3] = i_sin_seventh;
    assign w_cos_in[3] = i_cos_seventh;

    assign n_phase = (r_phase == hspd_pkg::PHASE_W'(PhaseMod - 1)) ? '0 : r_phase + 8'd1;

    // rom address per phase index and harmonic, worked out at elaboration
    for (genvar gh = 0; gh < NH; gh++) begin : g_tab_h
        for (genvar gi = 0; gi < 256; gi++) begin : g_tab_i
            assign w_addr_tab[gh][gi] = hspd_pkg::PHASE_W'(
                (((hspd_pkg::HARM_MUL[gh] * gi) % PhaseMod) * 256) / PhaseMod);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= hspd_pkg::DUTY_LIMIT_RESET;
            r_amp   <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                hspd_pkg::CFG_DUTY_LIMIT: r_limit <= i_cfg_data[10:0];
                hspd_pkg::CFG_JOIN_AMP:   r_amp   <= $signed(i_cfg_data);
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
        end else if (w_in_acc && i_mode == hspd_pkg::MODE_ADVANCE) begin
            r_phase <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_in_acc) begin
            r_s1_valid <= 1'b1;
        end else if (w_s2_en) begin
            r_s1_valid <= 1'b0;
        end
    end

    for (genvar gh = 0; gh < NH; gh++) begin : g_s1
        always_ff @(posedge i_clk) begin
            if (w_in_acc) begin
                r_s1_sin[gh]  <= w_sin_in[gh];
                r_s1_cos[gh]  <= w_cos_in[gh];
                r_s1_addr[gh] <= w_addr_tab[gh][r_phase];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_s1_mode <= i_mode;
            if (i_mode == hspd_pkg::MODE_ADVANCE) begin
                r_s1_phase  <= n_phase;
                r_s1_pstart <= (n_phase == '0);
                r_s1_svalid <= (n_phase[1:0] == 2'd0);
                r_s1_slot   <= (n_phase[1:0] == 2'd0) ? n_phase[7:2] : '0;
            end else begin
                r_s1_phase  <= r_phase;
                r_s1_pstart <= 1'b0;
                r_s1_svalid <= 1'b0;
                r_s1_slot   <= '0;
            end
        end
    end

    for (genvar gh = 0; gh < NH; gh++) begin : g_harm
        assign w_sin_v[gh] = hspd_pkg::sine_rom(r_s1_addr[gh]);
        assign w_cos_v[gh] = hspd_pkg::sine_rom(r_s1_addr[gh] + hspd_pkg::QUARTER_TURN);

        hspd_term u_term (
            .i_sin_val  (w_sin_v[gh]),
            .i_cos_val  (w_cos_v[gh]),
            .i_sin_coef (r_s1_sin[gh]),
            .i_cos_coef (r_s1_cos[gh]),
            .o_term     (w_term[gh])
        );
    end

    // fundamental drive, truncated toward zero
    assign w_drive_p    = w_sin_v[0] * r_amp;
    assign w_drive_bias = w_drive_p[33] ? 34'sd1048575 : '0;
    assign w_drive_sh   = (w_drive_p + w_drive_bias) >>> hspd_pkg::DRIVE_SHIFT;

    assign w_duty = 16'(w_drive_sh) - 16'(w_term[0]) - 16'(w_term[1])
                  - 16'(w_term[2]) - 16'(w_term[3]);
    assign w_lim  = $signed({5'b0, r_limit});

    always_comb begin
        priority if (w_duty > w_lim) begin
            w_duty_c = w_lim;
        end else if (w_duty < -w_lim) begin
            w_duty_c = -w_lim;
        end else begin
            w_duty_c = w_duty;
        end
    end

    assign w_duty_neg = -w_duty_c;

    always_comb begin
        n_high = '0;
        n_low  = '0;
        if (r_s1_mode == hspd_pkg::MODE_COMPUTE) begin
            if (w_duty_c[15]) begin
                n_low = w_duty_neg[10:0];
            end else begin
                n_high = w_duty_c[10:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_s2_en) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s2_en && r_s1_valid) begin
            r_high      <= n_high;
            r_low       <= n_low;
            r_phase_out <= r_s1_phase;
            r_pstart    <= r_s1_pstart;
            r_svalid    <= r_s1_svalid;
            r_slot      <= r_s1_slot;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_high_duty    = r_high;
    assign o_low_duty     = r_low;
    assign o_phase_index  = r_phase_out;
    assign o_period_start = r_pstart;
    assign o_slot_valid   = r_svalid;
    assign o_sample_slot  = r_slot;

    a_one_leg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_high_duty != '0) |-> (o_low_duty == '0))
        else $error("both duty legs non-zero");

    a_slot_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_slot_valid) |->
            (o_phase_index[1:0] == 2'd0 && o_sample_slot == o_phase_index[7:2]))
        else $error("sample slot does not match phase index");

    a_period_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_period_start) |-> (o_phase_index == '0 && o_slot_valid))
        else $error("period start away from index zero");

    a_item_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> r_s1_valid)
        else $error("accepted item lost from input stage");

endmodule
